// ===== hw/rtl/smx_pkg.sv =====
`timescale 1ns / 1ps

package smx_pkg;

  localparam int WORD_W = 32;
  localparam int PC_W   = 13;
  localparam int TGT_W  = 12;
  localparam int ST_W   = 4;
  localparam int EV_W   = 3;
  localparam int ADDR_W = 2;

  // Register byte addresses on the configuration port.
  localparam logic [ADDR_W-1:0] REG_PROGRAM_LENGTH = 2'd0;

  // Opcode bytes.
  localparam logic [7:0] OPC_NOP     = 8'h00;
  localparam logic [7:0] OPC_PUSH    = 8'h01;
  localparam logic [7:0] OPC_POP     = 8'h02;
  localparam logic [7:0] OPC_POKE    = 8'h03;
  localparam logic [7:0] OPC_PEEK    = 8'h04;
  localparam logic [7:0] OPC_PUTC    = 8'h05;
  localparam logic [7:0] OPC_REFRESH = 8'h06;
  localparam logic [7:0] OPC_ADD     = 8'h07;
  localparam logic [7:0] OPC_SUB     = 8'h08;
  localparam logic [7:0] OPC_JUMP    = 8'h09;
  localparam logic [7:0] OPC_WAIT    = 8'h0a;
  localparam logic [7:0] OPC_BRK     = 8'hfd;
  localparam logic [7:0] OPC_HALT    = 8'hfe;
  localparam logic [7:0] OPC_EXIT    = 8'hff;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 4'd0;
  localparam logic [ST_W-1:0] ST_SYNTAX   = 4'd1;
  localparam logic [ST_W-1:0] ST_INVALID  = 4'd2;
  localparam logic [ST_W-1:0] ST_END      = 4'd3;
  localparam logic [ST_W-1:0] ST_ADDRESS  = 4'd4;
  localparam logic [ST_W-1:0] ST_EMPTY    = 4'd5;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 4'd6;
  localparam logic [ST_W-1:0] ST_HALTED   = 4'd7;
  localparam logic [ST_W-1:0] ST_STOPPED  = 4'd8;
  localparam logic [ST_W-1:0] ST_NOPROG   = 4'd9;

  // Event codes.
  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_PUTC    = 3'd1;
  localparam logic [EV_W-1:0] EV_REFRESH = 3'd2;
  localparam logic [EV_W-1:0] EV_WAIT    = 3'd3;
  localparam logic [EV_W-1:0] EV_BREAK   = 3'd4;
  localparam logic [EV_W-1:0] EV_EXIT    = 3'd5;

  // Stack words consumed by put char and by add/sub.
  localparam int PUTC_WORDS  = 5;
  localparam int ARITH_WORDS = 2;

  // Operation class after decode; bad opcodes and parameter mismatches are
  // folded into their own classes so the executor sees one code.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_POKE,
    OP_PEEK,
    OP_PUTC,
    OP_REFRESH,
    OP_ADD,
    OP_SUB,
    OP_JUMP,
    OP_WAIT,
    OP_BRK,
    OP_HALT,
    OP_EXIT,
    OP_INVALID,
    OP_SYNTAX
  } op_t;

  typedef struct packed {
    logic              restart;
    op_t               op;
    logic              addr_ok;
    logic [WORD_W-1:0] param;
    logic [TGT_W-1:0]  target;
  } instr_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_POKE,
    BK_PEEK,
    BK_ARITH,
    BK_PUTC1,
    BK_PUTC2,
    BK_PUTC3
  } bk_state_t;

endpackage

// ===== hw/rtl/smx_front.sv =====
`timescale 1ns / 1ps

module smx_front #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                        kind,
  input  logic [7:0]                  opcode,
  input  logic                        has_param,
  input  logic signed [31:0]          param_value,
  input  logic [smx_pkg::TGT_W-1:0]   jump_target,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        q_push,
  output smx_pkg::instr_t             q_wdata
);

  localparam logic [smx_pkg::WORD_W-1:0] MEM_LIMIT = smx_pkg::WORD_W'(MEM_WORDS);

  smx_pkg::op_t op_cls;
  logic         want_param;
  logic         known;

  always_comb begin
    op_cls     = smx_pkg::OP_INVALID;
    want_param = 1'b0;
    known      = 1'b1;
    unique case (opcode)
      smx_pkg::OPC_NOP:     op_cls = smx_pkg::OP_NOP;
      smx_pkg::OPC_PUSH:    begin op_cls = smx_pkg::OP_PUSH; want_param = 1'b1; end
      smx_pkg::OPC_POP:     op_cls = smx_pkg::OP_POP;
      smx_pkg::OPC_POKE:    begin op_cls = smx_pkg::OP_POKE; want_param = 1'b1; end
      smx_pkg::OPC_PEEK:    begin op_cls = smx_pkg::OP_PEEK; want_param = 1'b1; end
      smx_pkg::OPC_PUTC:    op_cls = smx_pkg::OP_PUTC;
      smx_pkg::OPC_REFRESH: op_cls = smx_pkg::OP_REFRESH;
      smx_pkg::OPC_ADD:     op_cls = smx_pkg::OP_ADD;
      smx_pkg::OPC_SUB:     op_cls = smx_pkg::OP_SUB;
      smx_pkg::OPC_JUMP:    begin op_cls = smx_pkg::OP_JUMP; want_param = 1'b1; end
      smx_pkg::OPC_WAIT:    begin op_cls = smx_pkg::OP_WAIT; want_param = 1'b1; end
      smx_pkg::OPC_BRK:     op_cls = smx_pkg::OP_BRK;
      smx_pkg::OPC_HALT:    op_cls = smx_pkg::OP_HALT;
      smx_pkg::OPC_EXIT:    op_cls = smx_pkg::OP_EXIT;
      default:              known  = 1'b0;
    endcase
    // An unknown opcode outranks a parameter mismatch.
    if (known && (has_param != want_param)) begin
      op_cls = smx_pkg::OP_SYNTAX;
    end
  end

  assign in_ready = !q_full && !clearing;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_wdata.restart = kind;
    q_wdata.op      = op_cls;
    // Negative values are huge when read unsigned, so one compare covers both.
    q_wdata.addr_ok = ($unsigned(param_value) < MEM_LIMIT);
    q_wdata.param   = $unsigned(param_value);
    q_wdata.target  = jump_target;
  end

endmodule

// ===== hw/rtl/smx_queue.sv =====
`timescale 1ns / 1ps

module smx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smx_pkg::instr_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output smx_pkg::instr_t q_data
);

  smx_pkg::instr_t entries [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      level;

  assign full    = (level == 2'd2);
  assign q_valid = (level != 2'd0);
  assign q_data  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      level <= level + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("transfer into a full instruction queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> !pop)
    else $error("instruction queue popped while empty");

endmodule

// ===== hw/rtl/smx_back.sv =====
`timescale 1ns / 1ps

module smx_back #(
  parameter int MEM_WORDS   = 65536,
  parameter int STACK_DEPTH = 256,
  parameter int PROG_DEPTH  = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [smx_pkg::PC_W-1:0]   program_length,
  input  logic                       q_valid,
  input  smx_pkg::instr_t            q_data,
  output logic                       q_pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [smx_pkg::ST_W-1:0]   status,
  output logic [smx_pkg::PC_W-1:0]   next_pc,
  output logic [smx_pkg::EV_W-1:0]   event_res,
  output logic signed [31:0]         put_x,
  output logic signed [31:0]         put_y,
  output logic signed [31:0]         put_char,
  output logic signed [31:0]         put_fg,
  output logic signed [31:0]         put_bg,
  output logic signed [31:0]         wait_time
);

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int W   = smx_pkg::WORD_W;
  localparam int PCW = smx_pkg::PC_W;

  localparam logic [CW-1:0]  DEPTH_C   = CW'(STACK_DEPTH);
  localparam logic [CW-1:0]  PUTC_MIN  = CW'(smx_pkg::PUTC_WORDS);
  localparam logic [CW-1:0]  ARITH_MIN = CW'(smx_pkg::ARITH_WORDS);
  localparam logic [MAW-1:0] CLR_LAST  = MAW'(MEM_WORDS - 1);

  // Architectural state.
  smx_pkg::bk_state_t state, state_next;
  logic [PCW-1:0]     pc, pc_next;
  logic               running, running_next;
  logic               halted, halted_next;
  logic [CW-1:0]      count, count_next;
  logic [MAW-1:0]     clr_addr;
  smx_pkg::instr_t    cur;
  logic [W-1:0]       hold_bg, hold_fg, hold_ch, hold_y;

  // Memories and their registered read data.
  logic [W-1:0] stack_mem [STACK_DEPTH];
  logic [W-1:0] dmem [MEM_WORDS];
  logic [W-1:0] rd_a, rd_b, dm_rd;

  logic           sw_en, sr_en, dw_en, dr_en;
  logic [SAW-1:0] sw_addr, sr_addr_a, sr_addr_b;
  logic [W-1:0]   sw_data, dw_data;
  logic [MAW-1:0] dw_addr, dr_addr;

  logic [PCW-1:0] len;
  logic [CW-1:0]  cnt_m1, cnt_m2, cnt_m3, cnt_m4, cnt_m5;
  logic           out_free;
  logic [PCW-1:0] m_pc;
  logic           m_end;

  // Decision for the item at the head of the queue.
  logic [smx_pkg::ST_W-1:0] e_st;
  logic [smx_pkg::EV_W-1:0] e_ev;
  logic [W-1:0]             e_wt;
  logic                     e_multi, e_push, e_branch, e_ok, e_run, e_halt;
  smx_pkg::bk_state_t       e_mstate;
  logic [CW-1:0]            e_cnt;
  logic [PCW-1:0]           e_pc;

  // Result being loaded into the output register.
  logic                     res_load, cur_load, hold1, hold2;
  logic [smx_pkg::ST_W-1:0] res_status;
  logic [PCW-1:0]           res_pc;
  logic [smx_pkg::EV_W-1:0] res_event;
  logic [W-1:0]             res_x, res_y, res_ch, res_fg, res_bg, res_wt;

  assign len = (32'(program_length) < 32'(PROG_DEPTH)) ? program_length : PCW'(PROG_DEPTH);

  assign cnt_m1   = count - CW'(1);
  assign cnt_m2   = count - CW'(2);
  assign cnt_m3   = count - CW'(3);
  assign cnt_m4   = count - CW'(4);
  assign cnt_m5   = count - CW'(5);
  assign out_free = !out_valid || out_ready;
  assign clearing = (state == smx_pkg::BK_CLEAR);

  // Multi-cycle operations always end with a plain pc increment.
  assign m_pc  = pc + 1'b1;
  assign m_end = (m_pc >= len);

  always_comb begin
    e_st     = smx_pkg::ST_OK;
    e_ev     = smx_pkg::EV_NONE;
    e_wt     = '0;
    e_multi  = 1'b0;
    e_mstate = smx_pkg::BK_IDLE;
    e_push   = 1'b0;
    e_branch = 1'b0;
    e_ok     = 1'b0;
    e_run    = running;
    e_halt   = halted;
    e_cnt    = count;
    e_pc     = pc;
    if (q_data.restart) begin
      e_run  = 1'b1;
      e_halt = 1'b0;
      e_cnt  = '0;
      e_pc   = '0;
    end else if (len == '0) begin
      e_st = smx_pkg::ST_NOPROG;
    end else if (!running) begin
      e_st = smx_pkg::ST_STOPPED;
    end else if (halted) begin
      e_st = smx_pkg::ST_HALTED;
    end else if (pc >= len) begin
      e_st  = smx_pkg::ST_END;
      e_run = 1'b0;
    end else begin
      e_ok = 1'b1;
      unique case (q_data.op)
        smx_pkg::OP_NOP: ;
        smx_pkg::OP_PUSH: begin
          if (count >= DEPTH_C) begin
            e_st = smx_pkg::ST_OVERFLOW;
          end else begin
            e_push = 1'b1;
            e_cnt  = count + 1'b1;
          end
        end
        smx_pkg::OP_POP: begin
          if (count == '0) e_st = smx_pkg::ST_EMPTY;
          else e_cnt = cnt_m1;
        end
        smx_pkg::OP_POKE: begin
          if (!q_data.addr_ok) e_st = smx_pkg::ST_ADDRESS;
          else if (count == '0) e_st = smx_pkg::ST_EMPTY;
          else begin
            e_multi  = 1'b1;
            e_mstate = smx_pkg::BK_POKE;
          end
        end
        smx_pkg::OP_PEEK: begin
          if (!q_data.addr_ok) e_st = smx_pkg::ST_ADDRESS;
          else if (count >= DEPTH_C) e_st = smx_pkg::ST_OVERFLOW;
          else begin
            e_multi  = 1'b1;
            e_mstate = smx_pkg::BK_PEEK;
          end
        end
        smx_pkg::OP_PUTC: begin
          if (count < PUTC_MIN) e_st = smx_pkg::ST_EMPTY;
          else begin
            e_multi  = 1'b1;
            e_mstate = smx_pkg::BK_PUTC1;
          end
        end
        smx_pkg::OP_REFRESH: e_ev = smx_pkg::EV_REFRESH;
        smx_pkg::OP_ADD, smx_pkg::OP_SUB: begin
          if (count < ARITH_MIN) e_st = smx_pkg::ST_EMPTY;
          else begin
            e_multi  = 1'b1;
            e_mstate = smx_pkg::BK_ARITH;
          end
        end
        smx_pkg::OP_JUMP: e_branch = 1'b1;
        smx_pkg::OP_WAIT: begin
          e_wt = q_data.param;
          e_ev = smx_pkg::EV_WAIT;
        end
        smx_pkg::OP_BRK:     e_ev = smx_pkg::EV_BREAK;
        smx_pkg::OP_HALT:    e_halt = 1'b1;
        smx_pkg::OP_EXIT: begin
          e_run = 1'b0;
          e_ev  = smx_pkg::EV_EXIT;
        end
        smx_pkg::OP_INVALID: e_st = smx_pkg::ST_INVALID;
        smx_pkg::OP_SYNTAX:  e_st = smx_pkg::ST_SYNTAX;
      endcase
      if (e_st != smx_pkg::ST_OK) begin
        e_run = 1'b0;
        e_ok  = 1'b0;
        e_ev  = smx_pkg::EV_NONE;
        e_wt  = '0;
      end
    end
    // Successful step without a multi-cycle part: branch, or advance while running and not halted, then check the end.
    if (e_ok && !e_multi) begin
      if (e_branch) e_pc = PCW'(q_data.target);
      else if (e_run && !e_halt) e_pc = pc + 1'b1;
      if (e_pc >= len) begin
        e_st  = smx_pkg::ST_END;
        e_run = 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    pc_next      = pc;
    running_next = running;
    halted_next  = halted;
    count_next   = count;
    q_pop        = 1'b0;
    cur_load     = 1'b0;
    hold1        = 1'b0;
    hold2        = 1'b0;
    res_load     = 1'b0;
    res_status   = smx_pkg::ST_OK;
    res_pc       = pc;
    res_event    = smx_pkg::EV_NONE;
    res_x        = '0;
    res_y        = '0;
    res_ch       = '0;
    res_fg       = '0;
    res_bg       = '0;
    res_wt       = '0;
    sw_en        = 1'b0;
    sw_addr      = count[SAW-1:0];
    sw_data      = q_data.param;
    sr_en        = 1'b0;
    sr_addr_a    = cnt_m1[SAW-1:0];
    sr_addr_b    = cnt_m2[SAW-1:0];
    dw_en        = 1'b0;
    dw_addr      = clr_addr;
    dw_data      = '0;
    dr_en        = 1'b0;
    dr_addr      = q_data.param[MAW-1:0];
    unique case (state)
      smx_pkg::BK_CLEAR: begin
        dw_en = 1'b1;
        if (clr_addr == CLR_LAST) state_next = smx_pkg::BK_IDLE;
      end
      smx_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (e_multi) begin
            // Start the operand reads; the result follows in a later cycle.
            q_pop      = 1'b1;
            cur_load   = 1'b1;
            state_next = e_mstate;
            if (q_data.op == smx_pkg::OP_PEEK) dr_en = 1'b1;
            else sr_en = 1'b1;
          end else if (out_free) begin
            q_pop        = 1'b1;
            res_load     = 1'b1;
            res_status   = e_st;
            res_pc       = e_pc;
            res_event    = e_ev;
            res_wt       = e_wt;
            pc_next      = e_pc;
            running_next = e_run;
            halted_next  = e_halt;
            count_next   = e_cnt;
            sw_en        = e_push;
          end
        end
      end
      smx_pkg::BK_POKE: begin
        if (out_free) begin
          dw_en      = 1'b1;
          dw_addr    = cur.param[MAW-1:0];
          dw_data    = rd_a;
          count_next = cnt_m1;
          res_load   = 1'b1;
        end
      end
      smx_pkg::BK_PEEK: begin
        if (out_free) begin
          sw_en      = 1'b1;
          sw_data    = dm_rd;
          count_next = count + 1'b1;
          res_load   = 1'b1;
        end
      end
      smx_pkg::BK_ARITH: begin
        if (out_free) begin
          sw_en      = 1'b1;
          sw_addr    = cnt_m2[SAW-1:0];
          sw_data    = (cur.op == smx_pkg::OP_ADD) ? (rd_b + rd_a) : (rd_b - rd_a);
          count_next = cnt_m1;
          res_load   = 1'b1;
        end
      end
      smx_pkg::BK_PUTC1: begin
        hold1      = 1'b1;
        sr_en      = 1'b1;
        sr_addr_a  = cnt_m3[SAW-1:0];
        sr_addr_b  = cnt_m4[SAW-1:0];
        state_next = smx_pkg::BK_PUTC2;
      end
      smx_pkg::BK_PUTC2: begin
        hold2      = 1'b1;
        sr_en      = 1'b1;
        sr_addr_a  = cnt_m5[SAW-1:0];
        state_next = smx_pkg::BK_PUTC3;
      end
      smx_pkg::BK_PUTC3: begin
        if (out_free) begin
          count_next = cnt_m5;
          res_load   = 1'b1;
          res_event  = smx_pkg::EV_PUTC;
          res_x      = rd_a;
          res_y      = hold_y;
          res_ch     = hold_ch;
          res_fg     = hold_fg;
          res_bg     = hold_bg;
        end
      end
    endcase
    // Common finish for the multi-cycle operations.
    if (res_load && (state != smx_pkg::BK_IDLE)) begin
      res_pc       = m_pc;
      pc_next      = m_pc;
      res_status   = m_end ? smx_pkg::ST_END : smx_pkg::ST_OK;
      running_next = !m_end;
      state_next   = smx_pkg::BK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smx_pkg::BK_CLEAR;
      pc        <= '0;
      running   <= 1'b1;
      halted    <= 1'b0;
      count     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      running   <= running_next;
      halted    <= halted_next;
      count     <= count_next;
      out_valid <= res_load || (out_valid && !out_ready);
      if (state == smx_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status    <= res_status;
      next_pc   <= res_pc;
      event_res <= res_event;
      put_x     <= res_x;
      put_y     <= res_y;
      put_char  <= res_ch;
      put_fg    <= res_fg;
      put_bg    <= res_bg;
      wait_time <= res_wt;
    end
    if (cur_load) begin
      cur <= q_data;
    end
    if (hold1) begin
      hold_bg <= rd_a;
      hold_fg <= rd_b;
    end
    if (hold2) begin
      hold_ch <= rd_a;
      hold_y  <= rd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      stack_mem[sw_addr] <= sw_data;
    end
    if (sr_en) begin
      rd_a <= stack_mem[sr_addr_a];
      rd_b <= stack_mem[sr_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (dw_en) begin
      dmem[dw_addr] <= dw_data;
    end
    if (dr_en) begin
      dm_rd <= dmem[dr_addr];
    end
  end

  a_stall_holds_stack: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(count))
    else $error("stack depth changed while the result transfer was stalled");

  a_clear_is_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == smx_pkg::BK_CLEAR) |-> (!q_pop && !out_valid))
    else $error("instruction taken or result shown during memory clear");

  a_restart_state: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.restart) |=> (pc == '0 && count == '0 && running && !halted))
    else $error("restart did not reset pc, stack and flags");

  a_putc_operands: assert property (@(posedge clk) disable iff (rst)
    (state == smx_pkg::BK_PUTC1) |-> (count >= PUTC_MIN))
    else $error("put char sequence started without five stacked words");

endmodule

// ===== hw/rtl/stack_machine_executor.sv =====
`timescale 1ns / 1ps

// Stack machine executor: runs one pre-decoded instruction per input transfer
// and returns exactly one result transfer for it.
// Input channel (in_valid/in_ready) carries kind, opcode, has_param,
// param_value and jump_target; the output channel (out_valid/out_ready)
// carries status, next_pc, event and the put char / wait values.
// program_length is written over the APB port at byte address 0 while idle;
// the user must keep to that, the block itself does not enforce it. A front
// decoder classifies each instruction into a two-entry queue; the executor
// behind it owns pc, flags, the stack RAM and the data RAM. Each instruction
// is registered in the queue, its result in the output register; poke, peek,
// add and sub add one registered RAM read, and put char reads its five stack
// words two at a time on the stack RAM's two read ports. Most instructions
// sustain one per cycle while the output is not stalled; poke, peek, add and
// sub hold the executor in their own state, put char in BK_PUTC1 to BK_PUTC3.
// The data RAM is cleared after reset one word per cycle, and in_ready stays
// low until that finishes; APB writes still work. A stalled output holds its
// result; the queue keeps taking two more instructions, three when the first
// is a multi-cycle one that the executor can start, before in_ready drops.

module stack_machine_executor #(
  parameter int MEM_WORDS   = 65536,
  parameter int STACK_DEPTH = 256,
  parameter int PROG_DEPTH  = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smx_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        kind,
  input  logic [7:0]                  opcode,
  input  logic                        has_param,
  input  logic signed [31:0]          param_value,
  input  logic [smx_pkg::TGT_W-1:0]   jump_target,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic [smx_pkg::ST_W-1:0]    status,
  output logic [smx_pkg::PC_W-1:0]    next_pc,
  output logic [smx_pkg::EV_W-1:0]    event_res,
  output logic signed [31:0]          put_x,
  output logic signed [31:0]          put_y,
  output logic signed [31:0]          put_char,
  output logic signed [31:0]          put_fg,
  output logic signed [31:0]          put_bg,
  output logic signed [31:0]          wait_time,
  output logic                        out_valid,
  input  logic                        out_ready
);

  logic [smx_pkg::PC_W-1:0] program_length;
  logic                     cfg_write;

  logic            q_full, q_push, q_pop, q_valid, clearing;
  smx_pkg::instr_t q_wdata, q_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr == smx_pkg::REG_PROGRAM_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_write) begin
      program_length <= pwdata[smx_pkg::PC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == smx_pkg::REG_PROGRAM_LENGTH) begin
      prdata = {{(32 - smx_pkg::PC_W){1'b0}}, program_length};
    end
  end

  smx_front #(
    .MEM_WORDS (MEM_WORDS)
  ) u_front (
    .kind        (kind),
    .opcode      (opcode),
    .has_param   (has_param),
    .param_value (param_value),
    .jump_target (jump_target),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .q_full      (q_full),
    .clearing    (clearing),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  smx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  smx_back #(
    .MEM_WORDS   (MEM_WORDS),
    .STACK_DEPTH (STACK_DEPTH),
    .PROG_DEPTH  (PROG_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .program_length (program_length),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .next_pc        (next_pc),
    .event_res      (event_res),
    .put_x          (put_x),
    .put_y          (put_y),
    .put_char       (put_char),
    .put_fg         (put_fg),
    .put_bg         (put_bg),
    .wait_time      (wait_time)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import smx_pkg::*;

  localparam int MEM_SIZE   = 65536;
  localparam int STK_WORDS  = 256;
  localparam int PROG_SLOTS = 4096;
  localparam int PHASE_ITEMS = 440;

  typedef struct {
    logic              kind;
    logic [7:0]        opc;
    logic              hp;
    logic [WORD_W-1:0] param;
    logic [TGT_W-1:0]  tgt;
  } instr_item_t;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [PC_W-1:0]   pc;
    logic [EV_W-1:0]   ev;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] ch;
    logic [WORD_W-1:0] fg;
    logic [WORD_W-1:0] bg;
    logic [WORD_W-1:0] wt;
  } step_result_t;

  // Mirror of the machine: computes the result of every accepted instruction
  // and holds those results until the block delivers them.
  class machine_tracker;
    int unsigned  prog_len;
    int unsigned  pc;
    int unsigned  depth;
    bit           running;
    bit           halted;
    bit [31:0]    stk [STK_WORDS];
    bit [31:0]    mem [MEM_SIZE];
    step_result_t pending_results[$];
    int unsigned  mismatches;
    int unsigned  results_seen;
    int unsigned  items_seen;
    int unsigned  restarts;
    int unsigned  putc_hits;
    int unsigned  status_hits[16];

    function new();
      prog_len = 0;
      restart();
    endfunction

    function void restart();
      pc = 0;
      running = 1'b1;
      halted = 1'b0;
      depth = 0;
    endfunction

    function bit takes_param(logic [7:0] op);
      return op == OPC_PUSH || op == OPC_POKE || op == OPC_PEEK ||
             op == OPC_JUMP || op == OPC_WAIT;
    endfunction

    function void push_word(bit [31:0] v);
      stk[depth] = v;
      depth++;
    endfunction

    function bit [31:0] pop_word();
      depth--;
      return stk[depth];
    endfunction

    function void accept_instr(instr_item_t it);
      step_result_t r;
      int unsigned  plen;
      bit           addr_ok;
      bit           branch;
      bit [31:0]    a;
      bit [31:0]    b;
      r = '{default: '0};
      r.status = ST_OK;
      r.ev = EV_NONE;
      branch = 1'b0;
      plen = (prog_len < PROG_SLOTS) ? prog_len : PROG_SLOTS;
      addr_ok = !it.param[31] && (it.param < MEM_SIZE);
      items_seen++;
      if (it.kind) begin
        restart();
        restarts++;
      end else if (plen == 0) begin
        r.status = ST_NOPROG;
      end else if (!running) begin
        r.status = ST_STOPPED;
      end else if (halted) begin
        r.status = ST_HALTED;
      end else if (pc >= plen) begin
        r.status = ST_END;
        running = 1'b0;
      end else begin
        if (!(it.opc <= OPC_WAIT || it.opc >= OPC_BRK)) begin
          r.status = ST_INVALID;
        end else if (it.hp != takes_param(it.opc)) begin
          r.status = ST_SYNTAX;
        end else begin
          case (it.opc)
            OPC_PUSH: begin
              if (depth >= STK_WORDS) r.status = ST_OVERFLOW;
              else push_word(it.param);
            end
            OPC_POP: begin
              if (depth == 0) r.status = ST_EMPTY;
              else void'(pop_word());
            end
            OPC_POKE: begin
              if (!addr_ok) r.status = ST_ADDRESS;
              else if (depth == 0) r.status = ST_EMPTY;
              else mem[it.param[15:0]] = pop_word();
            end
            OPC_PEEK: begin
              if (!addr_ok) r.status = ST_ADDRESS;
              else if (depth >= STK_WORDS) r.status = ST_OVERFLOW;
              else push_word(mem[it.param[15:0]]);
            end
            OPC_PUTC: begin
              if (depth < PUTC_WORDS) begin
                r.status = ST_EMPTY;
              end else begin
                r.bg = pop_word();
                r.fg = pop_word();
                r.ch = pop_word();
                r.y = pop_word();
                r.x = pop_word();
                r.ev = EV_PUTC;
              end
            end
            OPC_REFRESH: r.ev = EV_REFRESH;
            OPC_ADD, OPC_SUB: begin
              if (depth < ARITH_WORDS) begin
                r.status = ST_EMPTY;
              end else begin
                b = pop_word();
                a = pop_word();
                push_word(it.opc == OPC_ADD ? a + b : a - b);
              end
            end
            OPC_JUMP: begin
              pc = 32'(it.tgt);
              branch = 1'b1;
            end
            OPC_WAIT: begin
              r.wt = it.param;
              r.ev = EV_WAIT;
            end
            OPC_BRK: r.ev = EV_BREAK;
            OPC_HALT: halted = 1'b1;
            OPC_EXIT: begin
              running = 1'b0;
              r.ev = EV_EXIT;
            end
            default: ;
          endcase
        end
        if (r.status != ST_OK) begin
          running = 1'b0;
        end else begin
          if (running && !halted && !branch) pc++;
          // The event of the last step is still reported at end of program.
          if (pc >= plen) begin
            running = 1'b0;
            r.status = ST_END;
          end
        end
      end
      r.pc = pc[PC_W-1:0];
      status_hits[r.status]++;
      if (r.ev == EV_PUTC) putc_hits++;
      pending_results.insert(pending_results.size(), r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at result %0d: %s got %h expected %h",
               results_seen, what, got, want);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(name, got, want);
    endtask

    task check_result(step_result_t got);
      step_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", 32'(got.status), '0);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("next_pc", 32'(got.pc), 32'(want.pc));
        compare_field("event_res", 32'(got.ev), 32'(want.ev));
        compare_field("put_x", got.x, want.x);
        compare_field("put_y", got.y, want.y);
        compare_field("put_char", got.ch, want.ch);
        compare_field("put_fg", got.fg, want.fg);
        compare_field("put_bg", got.bg, want.bg);
        compare_field("wait_time", got.wt, want.wt);
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                kind;
  logic [7:0]          opcode;
  logic                has_param;
  logic signed [31:0]  param_value;
  logic [TGT_W-1:0]    jump_target;
  logic                in_valid;
  logic                in_ready;
  logic [ST_W-1:0]     status;
  logic [PC_W-1:0]     next_pc;
  logic [EV_W-1:0]     event_res;
  logic signed [31:0]  put_x;
  logic signed [31:0]  put_y;
  logic signed [31:0]  put_char;
  logic signed [31:0]  put_fg;
  logic signed [31:0]  put_bg;
  logic signed [31:0]  wait_time;
  logic                out_valid;
  logic                out_ready;

  machine_tracker machine;
  int unsigned    accepted_instrs;
  int unsigned    send_idle;
  int unsigned    recv_idle;
  int unsigned    mid_len;
  bit             filling;

  stack_machine_executor #(
    .MEM_WORDS  (MEM_SIZE),
    .STACK_DEPTH(STK_WORDS),
    .PROG_DEPTH (PROG_SLOTS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .kind       (kind),
    .opcode     (opcode),
    .has_param  (has_param),
    .param_value(param_value),
    .jump_target(jump_target),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .status     (status),
    .next_pc    (next_pc),
    .event_res  (event_res),
    .put_x      (put_x),
    .put_y      (put_y),
    .put_char   (put_char),
    .put_fg     (put_fg),
    .put_bg     (put_bg),
    .wait_time  (wait_time),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[stack_machine_executor] ERROR");
    $finish;
  end

  always @(posedge clk) begin : watch
    instr_item_t  seen;
    step_result_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.kind = kind;
        seen.opc = opcode;
        seen.hp = has_param;
        seen.param = param_value;
        seen.tgt = jump_target;
        machine.accept_instr(seen);
        accepted_instrs++;
      end
      if (out_valid && out_ready) begin
        got.status = status;
        got.pc = next_pc;
        got.ev = event_res;
        got.x = put_x;
        got.y = put_y;
        got.ch = put_char;
        got.fg = put_fg;
        got.bg = put_bg;
        got.wt = wait_time;
        machine.check_result(got);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(input instr_item_t it);
    int unsigned goal;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind <= it.kind;
    opcode <= it.opc;
    has_param <= it.hp;
    param_value <= it.param;
    jump_target <= it.tgt;
    in_valid <= 1'b1;
    goal = accepted_instrs + 1;
    do @(negedge clk); while (accepted_instrs != goal);
  endtask

  task automatic do_instr(logic [7:0] op, logic hp, logic [31:0] p, logic [TGT_W-1:0] t);
    instr_item_t it;
    it.kind = 1'b0;
    it.opc = op;
    it.hp = hp;
    it.param = p;
    it.tgt = t;
    send_item(it);
  endtask

  task automatic do_restart();
    instr_item_t it;
    it.kind = 1'b1;
    it.opc = 8'($urandom);
    it.hp = 1'($urandom);
    it.param = $urandom;
    it.tgt = TGT_W'($urandom);
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (machine.pending_results.size() != 0);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    machine.prog_len = 32'(data[PC_W-1:0]);
  endtask

  function automatic logic [31:0] pick_addr();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 70) return $urandom_range(0, 31);
    if (w < 80) return $urandom_range(MEM_SIZE - 32, MEM_SIZE - 1);
    if (w < 85) return MEM_SIZE;
    if (w < 92) return 32'h8000_0000 | $urandom;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(9) != 0) return $urandom;
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h7fff_ffff;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // Mostly well-formed programs so that the stack and memory get exercised;
  // a stopped machine is usually restarted, and now and then the stack is
  // filled to the brim and then pushed or peeked once more.
  function automatic instr_item_t pick_instr();
    instr_item_t it;
    int unsigned plen;
    int unsigned w;
    it.kind = 1'b0;
    it.opc = 8'($urandom);
    it.hp = 1'($urandom);
    it.param = $urandom;
    it.tgt = TGT_W'($urandom);
    plen = (machine.prog_len < PROG_SLOTS) ? machine.prog_len : PROG_SLOTS;
    if (filling) begin
      it.hp = 1'b1;
      if (machine.depth < STK_WORDS) begin
        it.opc = OPC_PUSH;
      end else begin
        it.opc = $urandom_range(1) ? OPC_PUSH : OPC_PEEK;
        it.param = $urandom_range(0, 63);
        filling = 1'b0;
      end
      return it;
    end
    if (plen >= 300 && $urandom_range(299) == 0) begin
      filling = 1'b1;
      it.kind = 1'b1;
      return it;
    end
    if ((!machine.running || machine.halted || machine.pc >= plen) &&
        $urandom_range(9) < 8) begin
      it.kind = 1'b1;
      return it;
    end
    if ($urandom_range(99) < 2) begin
      it.kind = 1'b1;
      return it;
    end
    w = $urandom_range(99);
    if (w < 28) it.opc = OPC_PUSH;
    else if (w < 33) it.opc = OPC_POP;
    else if (w < 41) it.opc = OPC_POKE;
    else if (w < 50) it.opc = OPC_PEEK;
    else if (w < 57) it.opc = OPC_PUTC;
    else if (w < 60) it.opc = OPC_REFRESH;
    else if (w < 67) it.opc = OPC_ADD;
    else if (w < 74) it.opc = OPC_SUB;
    else if (w < 78) it.opc = OPC_JUMP;
    else if (w < 82) it.opc = OPC_WAIT;
    else if (w < 85) it.opc = OPC_BRK;
    else if (w < 87) it.opc = OPC_HALT;
    else if (w < 89) it.opc = OPC_EXIT;
    else if (w < 93) it.opc = OPC_NOP;
    else if (w < 96) it.opc = 8'($urandom_range(OPC_WAIT + 1, OPC_BRK - 1));
    else it.opc = $urandom_range(1) ? 8'($urandom_range(OPC_NOP, OPC_WAIT))
                                    : 8'($urandom_range(OPC_BRK, OPC_EXIT));
    if (it.opc == OPC_PUTC && machine.depth < PUTC_WORDS && $urandom_range(9) < 7)
      it.opc = OPC_PUSH;
    it.hp = machine.takes_param(it.opc);
    if (w >= 96) it.hp = !it.hp;
    if (it.opc == OPC_PUSH) it.param = pick_value();
    if (it.opc == OPC_POKE || it.opc == OPC_PEEK) it.param = pick_addr();
    if (it.opc == OPC_JUMP && plen > 0 && $urandom_range(9) < 8)
      it.tgt = TGT_W'($urandom_range(0, plen - 1));
    return it;
  endfunction

  initial begin
    machine = new();
    accepted_instrs = 0;
    filling = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    kind = 1'b0;
    opcode = '0;
    has_param = 1'b0;
    param_value = '0;
    jump_target = '0;
    in_valid = 1'b0;
    send_idle = 35;
    recv_idle = 74;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Program length still at its reset value of zero.
    do_instr(OPC_NOP, 1'b0, 32'h0, '0);
    do_restart();
    do_instr(OPC_PUSH, 1'b1, 32'h1234_5678, '0);
    wait_drained();
    apb_write(REG_PROGRAM_LENGTH, 32'd1);
    do_instr(OPC_NOP, 1'b0, 32'h0, '0);
    do_instr(OPC_NOP, 1'b0, 32'h0, '0);
    wait_drained();
    apb_write(REG_PROGRAM_LENGTH, PROG_SLOTS);

    do_restart();
    do_instr(OPC_PUSH, 1'b1, 32'h7fff_ffff, '0);
    do_instr(OPC_PUSH, 1'b1, 32'h0000_0001, '0);
    do_instr(OPC_ADD, 1'b0, 32'h0, '0);
    do_instr(OPC_PUSH, 1'b1, 32'h0000_0001, '0);
    do_instr(OPC_SUB, 1'b0, 32'h0, '0);
    do_instr(OPC_POKE, 1'b1, MEM_SIZE - 1, '0);
    do_instr(OPC_PEEK, 1'b1, MEM_SIZE - 1, '0);
    do_instr(OPC_PUSH, 1'b1, 32'h0000_0000, '0);
    do_instr(OPC_PUSH, 1'b1, 32'hffff_ffff, '0);
    do_instr(OPC_PUSH, 1'b1, 32'h5555_5555, '0);
    do_instr(OPC_PUSH, 1'b1, 32'haaaa_aaaa, '0);
    do_instr(OPC_PUTC, 1'b0, 32'h0, '0);
    do_instr(OPC_REFRESH, 1'b0, 32'h0, '0);
    do_instr(OPC_WAIT, 1'b1, 32'hffff_ffff, '0);
    do_instr(OPC_BRK, 1'b0, 32'h0, '1);
    do_instr(OPC_JUMP, 1'b1, 32'h0, '1);
    do_instr(OPC_HALT, 1'b0, 32'h0, '0);
    do_instr(OPC_NOP, 1'b0, 32'h0, '0);
    do_restart();
    do_instr(OPC_NOP, 1'b1, 32'h0, '0);
    do_restart();
    do_instr(OPC_WAIT + 8'd1, 1'b0, 32'h0, '0);
    do_restart();
    do_instr(OPC_PEEK, 1'b1, MEM_SIZE, '0);
    do_restart();
    do_instr(OPC_POP, 1'b0, 32'h0, '0);
    do_restart();
    do_instr(OPC_EXIT, 1'b0, 32'h0, '0);
    do_instr(OPC_NOP, 1'b0, 32'h0, '0);
    do_restart();
    // A jump to the last slot followed by one step runs off the program.
    do_instr(OPC_JUMP, 1'b1, 32'h0, '1);
    do_instr(OPC_NOP, 1'b0, 32'h0, '0);

    mid_len = $urandom_range(16, 600);
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          send_idle = 35;
          recv_idle = 74;
          apb_write(REG_PROGRAM_LENGTH, PROG_SLOTS);
        end
        1: begin
          send_idle = 74;
          recv_idle = 35;
          apb_write(REG_PROGRAM_LENGTH, mid_len);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          apb_write(REG_PROGRAM_LENGTH, PROG_SLOTS);
          filling = 1'b1;
          do_restart();
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold off once until the block has returned every result.
        if (ph == 0 && i == PHASE_ITEMS / 2) wait_drained();
        send_item(pick_instr());
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (machine.pending_results.size() != 0)
      machine.report_mismatch("results never delivered", machine.pending_results.size(), 0);
    $display("Ran %0d instructions (%0d restarts) with program lengths 0, 1, %0d and %0d,",
             machine.items_seen, machine.restarts, mid_len, PROG_SLOTS);
    $display("  %0d ok, %0d end of program, %0d put char, %0d overflow, %0d stopped.",
             machine.status_hits[ST_OK], machine.status_hits[ST_END], machine.putc_hits,
             machine.status_hits[ST_OVERFLOW], machine.status_hits[ST_STOPPED]);
    if (machine.mismatches == 0) begin
      $display("[stack_machine_executor] OK");
    end else begin
      $display("[stack_machine_executor] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/smx_pkg.sv
hw/rtl/smx_front.sv
hw/rtl/smx_queue.sv
hw/rtl/smx_back.sv
hw/rtl/stack_machine_executor.sv
verif/testbench.sv
